// ===== rtl/core/sls_pkg.sv =====
package sls_pkg;

  localparam int COORD_W = 16;
  localparam int Z_W     = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [Z_W-1:0]     floor_t;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  typedef struct packed {
    logic   cmd;
    coord_t pos_x;
    coord_t pos_y;
    floor_t pos_z;
  } in_item_t;

  typedef struct packed {
    coord_t tile_x;
    coord_t tile_y;
    floor_t tile_z;
    logic   last_of_run;
    logic   span_overflow;
  } out_item_t;

  // one queued line job; a lone point is a line of zero length
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    floor_t z;
    coord_t dx;
    coord_t dy;
    logic   sx;
    logic   sy;
    logic   ovf;
  } seg_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

// ===== rtl/core/sls_front.sv =====
module sls_front
  import sls_pkg::*;
#(
  parameter int MAX_SPAN = 63
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output seg_t     push_seg
);

  coord_t prev_x_r, prev_x_nxt;
  coord_t prev_y_r, prev_y_nxt;
  floor_t prev_z_r, prev_z_nxt;
  logic   have_prev_r, have_prev_nxt;

  logic   accept;
  logic   x_up, y_up;
  coord_t dx, dy;
  logic   too_long;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign x_up     = in_data.pos_x >= prev_x_r;
  assign y_up     = in_data.pos_y >= prev_y_r;
  assign dx       = x_up ? in_data.pos_x - prev_x_r : prev_x_r - in_data.pos_x;
  assign dy       = y_up ? in_data.pos_y - prev_y_r : prev_y_r - in_data.pos_y;
  assign too_long = (dx > COORD_W'(MAX_SPAN)) || (dy > COORD_W'(MAX_SPAN));

  assign push = accept && (in_data.cmd == CMD_POINT);

  always_comb begin
    if (!have_prev_r || too_long) begin
      push_seg.x0  = in_data.pos_x;
      push_seg.y0  = in_data.pos_y;
      push_seg.z   = in_data.pos_z;
      push_seg.dx  = '0;
      push_seg.dy  = '0;
      push_seg.ovf = have_prev_r;
    end else begin
      push_seg.x0  = prev_x_r;
      push_seg.y0  = prev_y_r;
      push_seg.z   = prev_z_r;
      push_seg.dx  = dx;
      push_seg.dy  = dy;
      push_seg.ovf = 1'b0;
    end
    push_seg.x1 = in_data.pos_x;
    push_seg.y1 = in_data.pos_y;
    push_seg.sx = in_data.pos_x > prev_x_r;
    push_seg.sy = in_data.pos_y > prev_y_r;
  end

  always_comb begin
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    prev_z_nxt    = prev_z_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_data.cmd == CMD_BEGIN) begin
        have_prev_nxt = 1'b0;
      end else begin
        prev_x_nxt    = in_data.pos_x;
        prev_y_nxt    = in_data.pos_y;
        prev_z_nxt    = in_data.pos_z;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      have_prev_r <= 1'b0;
    end else begin
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      prev_z_r    <= prev_z_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

// ===== rtl/core/sls_queue.sv =====
module sls_queue
  import sls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  seg_t    push_seg,
  input  logic    pop,
  output seg_t    pop_seg,
  output q_stat_t q_stat
);

  seg_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_stat.full      = cnt_r == 2'd2;
  assign q_stat.not_empty = cnt_r != 2'd0;
  assign do_push          = push && !q_stat.full;
  assign do_pop           = pop && q_stat.not_empty;
  assign pop_seg          = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/sls_back.sv =====
module sls_back
  import sls_pkg::*;
#(
  parameter int MAX_SPAN = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  seg_t      pop_seg,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int ERR_W  = SPAN_W + 3;

  typedef enum logic {ST_IDLE, ST_WALK} state_t;

  state_t                   state_r;
  coord_t                   x_r, y_r, x1_r, y1_r;
  floor_t                   z_r;
  logic [SPAN_W-1:0]        dx_r, dy_r, cnt_r;
  logic                     sx_r, sy_r, ovf_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic signed [ERR_W:0]    e2, dx_e, ndy_e, err_sum, init_sum;
  logic signed [ERR_W:0]    in_dx_e, in_dy_e;
  logic                     xstep, ystep, last, can_emit;
  coord_t                   x_nxt, y_nxt;

  assign e2    = {err_r, 1'b0};
  assign dx_e  = {{(ERR_W + 1 - SPAN_W){1'b0}}, dx_r};
  assign ndy_e = -{{(ERR_W + 1 - SPAN_W){1'b0}}, dy_r};
  assign xstep = e2 >= ndy_e;
  assign ystep = e2 <= dx_e;

  // the walk stops at the end point, at the tile limit, or where a step
  // would run past the end on an axis that is already done
  assign last = ((x_r == x1_r) && (y_r == y1_r)) || (cnt_r == SPAN_W'(MAX_SPAN)) ||
                (xstep && (x_r == x1_r)) || (ystep && (y_r == y1_r));

  assign err_sum = {err_r[ERR_W-1], err_r} + (xstep ? ndy_e : '0) + (ystep ? dx_e : '0);
  assign x_nxt   = xstep ? x_r + (sx_r ? COORD_W'(1) : {COORD_W{1'b1}}) : x_r;
  assign y_nxt   = ystep ? y_r + (sy_r ? COORD_W'(1) : {COORD_W{1'b1}}) : y_r;

  assign in_dx_e  = {{(ERR_W + 1 - SPAN_W){1'b0}}, pop_seg.dx[SPAN_W-1:0]};
  assign in_dy_e  = {{(ERR_W + 1 - SPAN_W){1'b0}}, pop_seg.dy[SPAN_W-1:0]};
  assign init_sum = in_dx_e - in_dy_e;

  assign can_emit  = !out_valid_r || out_ready;
  assign pop       = (state_r == ST_IDLE) && q_stat.not_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (q_stat.not_empty) begin
            x_r     <= pop_seg.x0;
            y_r     <= pop_seg.y0;
            x1_r    <= pop_seg.x1;
            y1_r    <= pop_seg.y1;
            z_r     <= pop_seg.z;
            dx_r    <= pop_seg.dx[SPAN_W-1:0];
            dy_r    <= pop_seg.dy[SPAN_W-1:0];
            sx_r    <= pop_seg.sx;
            sy_r    <= pop_seg.sy;
            ovf_r   <= pop_seg.ovf;
            err_r   <= init_sum[ERR_W-1:0];
            cnt_r   <= '0;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          // a tile still waiting for the receiver holds the walk
          if (can_emit) begin
            out_valid_r                <= 1'b1;
            out_data_r.tile_x          <= x_r;
            out_data_r.tile_y          <= y_r;
            out_data_r.tile_z          <= z_r;
            out_data_r.last_of_run     <= last;
            out_data_r.span_overflow   <= ovf_r;
            if (last) begin
              state_r <= ST_IDLE;
            end else begin
              x_r   <= x_nxt;
              y_r   <= y_nxt;
              err_r <= err_sum[ERR_W-1:0];
              cnt_r <= cnt_r + SPAN_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/stroke_line_stepper_core.sv =====
// Stroke line stepper: turns a stream of stroke points into tiles.
// Input channel in_valid/in_ready/in_data carries commands: begin stroke
// (no output) or a stroke point. Output channel out_valid/out_ready/out_data
// carries one tile per transaction; last_of_run marks the final tile of the
// run caused by one point.
// The first point of a stroke, and any move longer than MAX_SPAN tiles on
// either axis (span_overflow set), gives the point alone. Otherwise every
// tile on the Bresenham line from the stored point to the new one is given,
// both ends included, on the stored point's floor.
// A combinational front end classifies each point as it is accepted and
// queues a line job in a two-entry queue. The walker loads a job in its idle
// state, then gives one tile per cycle while the receiver does not stall.
// With an idle walker, an accepted point is written into the queue, loaded
// by the walker from there, and its first tile set in the output register.
// While the receiver stalls, the walker holds its tile in the output register
// and the front keeps accepting until the queue is full.
// Reset (rst_n low, synchronous) forgets the stored point, empties the queue
// and drops any tile not yet delivered.
module stroke_line_stepper_core
  import sls_pkg::*;
#(
  parameter int MAX_SPAN = 63
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    push, pop;
  seg_t    push_seg, pop_seg;

  sls_front #(.MAX_SPAN(MAX_SPAN)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_seg (push_seg)
  );

  sls_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_seg (push_seg),
    .pop      (pop),
    .pop_seg  (pop_seg),
    .q_stat   (q_stat)
  );

  sls_back #(.MAX_SPAN(MAX_SPAN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_seg   (pop_seg),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sls_pkg::*;

  localparam int MAX_SPAN    = 63;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int RAND_ITEMS  = 220;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYC  = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  stroke_line_stepper_core #(
    .MAX_SPAN(MAX_SPAN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // predictor state: stored stroke point
  int        anchor_x = 0;
  int        anchor_y = 0;
  floor_t    anchor_z = '0;
  bit        have_anchor = 1'b0;

  out_item_t expected_tiles[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        gap_len = 0;

  // receiver stall pattern
  int        ready_mode = 0;
  int        mode_left = 0;
  int        hold_left = 0;
  int        pat_cnt = 0;

  function automatic in_item_t make_item(logic cmd, int x, int y, int z);
    in_item_t it;
    it.cmd   = cmd;
    it.pos_x = coord_t'(x);
    it.pos_y = coord_t'(y);
    it.pos_z = floor_t'(z);
    return it;
  endfunction

  task automatic queue_tile(input out_item_t t);
    expected_tiles.insert(expected_tiles.size(), t);
  endtask

  // Expands one accepted transaction into the tiles it must produce.
  // A tile is held back one step so the final one can carry last_of_run.
  task automatic expand_stroke_point(input in_item_t it);
    int        x0, y0, x1, y1, dx, dy, sx, sy, err, e2, span, count;
    bit        done, held;
    out_item_t t, pend;
    if (it.cmd == CMD_BEGIN) begin
      have_anchor = 1'b0;
    end else if (!have_anchor) begin
      t.tile_x        = it.pos_x;
      t.tile_y        = it.pos_y;
      t.tile_z        = it.pos_z;
      t.last_of_run   = 1'b1;
      t.span_overflow = 1'b0;
      queue_tile(t);
    end else begin
      x0 = anchor_x;
      y0 = anchor_y;
      x1 = int'(it.pos_x);
      y1 = int'(it.pos_y);
      dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
      dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
      span = (dx > dy) ? dx : dy;
      if (span > MAX_SPAN) begin
        t.tile_x        = it.pos_x;
        t.tile_y        = it.pos_y;
        t.tile_z        = it.pos_z;
        t.last_of_run   = 1'b1;
        t.span_overflow = 1'b1;
        queue_tile(t);
      end else begin
        dy    = -dy;
        sx    = (x0 < x1) ? 1 : -1;
        sy    = (y0 < y1) ? 1 : -1;
        err   = dx + dy;
        count = 0;
        done  = 1'b0;
        held  = 1'b0;
        while (!done) begin
          if (held) queue_tile(pend);
          pend.tile_x        = coord_t'(x0);
          pend.tile_y        = coord_t'(y0);
          pend.tile_z        = anchor_z;
          pend.last_of_run   = 1'b0;
          pend.span_overflow = 1'b0;
          held  = 1'b1;
          count++;
          if ((x0 == x1 && y0 == y1) || count >= MAX_SPAN + 1) begin
            done = 1'b1;
          end else begin
            e2 = 2 * err;
            if (e2 >= dy) begin
              if (x0 == x1) begin
                done = 1'b1;
              end else begin
                err += dy;
                x0  += sx;
              end
            end
            if (!done && e2 <= dx) begin
              if (y0 == y1) begin
                done = 1'b1;
              end else begin
                err += dx;
                y0  += sy;
              end
            end
          end
        end
        pend.last_of_run = 1'b1;
        queue_tile(pend);
      end
    end
    if (it.cmd == CMD_POINT) begin
      anchor_x    = int'(it.pos_x);
      anchor_y    = int'(it.pos_y);
      anchor_z    = it.pos_z;
      have_anchor = 1'b1;
    end
  endtask

  // Sends one transaction; valid is only dropped when a gap follows.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expand_stroke_point(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
  endtask

  task automatic send_point(input int x, input int y, input int z);
    send_item(make_item(CMD_POINT, x, y, z));
  endtask

  // begin carries junk coordinates, which must be ignored
  task automatic send_begin();
    send_item(make_item(CMD_BEGIN, $urandom_range(0, COORD_MAX),
                        $urandom_range(0, COORD_MAX), $urandom_range(0, 15)));
  endtask

  task automatic wait_tiles_drained();
    in_valid <= 1'b0;
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic int pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 60) return int'($urandom_range(0, 30)) - 15;
    if (r < 85) return int'($urandom_range(0, 126)) - 63;
    if (r < 93) return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(63, 64));
    return ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(65, 400));
  endfunction

  function automatic int move_coord(int p, int d);
    int n;
    n = p + d;
    if (n < 0 || n > COORD_MAX) n = p - d;
    return n;
  endfunction

  // point with no stroke begun, repeat of the stored point, begin handling
  task automatic test_first_point();
    send_point(0, 0, 15);
    send_point(0, 0, 3);
    send_begin();
    send_begin();
    send_point(500, 700, 9);
    send_begin();
    send_point(500, 700, 2);
    wait_tiles_drained();
  endtask

  // every octant plus both axes, chained from one centre
  task automatic test_line_octants();
    int cx, cy, i;
    int ox[10] = '{20, 5, -5, -20, -20, -5, 5, 20, 0, -30};
    int oy[10] = '{5, 20, 20, 5, -5, -20, -20, -5, 30, 0};
    send_begin();
    cx = 1000;
    cy = 1000;
    send_point(cx, cy, 6);
    for (i = 0; i < 10; i++) begin
      cx += ox[i];
      cy += oy[i];
      send_point(cx, cy, i);
    end
    send_point(cx + 17, cy + 17, 0);
    wait_tiles_drained();
  endtask

  // longest legal move, one past it, and moves at the coordinate limits
  task automatic test_span_limits();
    send_begin();
    send_point(100, 200, 1);
    send_point(163, 200, 4);
    send_point(227, 200, 7);
    send_point(227, 137, 12);
    send_begin();
    send_point(COORD_MAX, COORD_MAX, 0);
    send_point(COORD_MAX - 63, COORD_MAX - 10, 15);
    send_point(0, 0, 5);
    send_point(0, 63, 8);
    wait_tiles_drained();
  endtask

  // random strokes, mostly well-formed, with some broken sequences of random commands
  task automatic test_random_strokes();
    int sent, n, i, px, py;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if ($urandom_range(0, 7) != 0) begin
        send_begin();
        sent++;
      end
      px = $urandom_range(0, COORD_MAX);
      py = $urandom_range(0, COORD_MAX);
      send_point(px, py, $urandom_range(0, 15));
      sent++;
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) begin
        px = move_coord(px, pick_step());
        py = move_coord(py, pick_step());
        send_point(px, py, $urandom_range(0, 15));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        // hold off the sender until the block has gone quiet
        wait_tiles_drained();
      end else if ($urandom_range(0, 4) == 0) begin
        // broken sequence: random commands and far points
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX), $urandom_range(0, 15)));
          sent++;
        end
      end
    end
    wait_tiles_drained();
  endtask

  // receiver stall pattern, changing mode now and then
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(32, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    pat_cnt <= pat_cnt + 1;
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= (pat_cnt % 4 == 0);
      end
      default: begin
        if (hold_left == 0) begin
          out_ready <= ~out_ready;
          hold_left <= $urandom_range(0, 8);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tiles.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0d: unexpected tile x=%0d y=%0d z=%0d last=%0b ovf=%0b",
                   cycle_count, out_data.tile_x, out_data.tile_y, out_data.tile_z,
                   out_data.last_of_run, out_data.span_overflow);
      end else begin
        want = expected_tiles.pop_front();
        if (out_data.tile_x !== want.tile_x || out_data.tile_y !== want.tile_y ||
            out_data.tile_z !== want.tile_z ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.span_overflow !== want.span_overflow) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0d: tile mismatch exp x=%0d y=%0d z=%0d l=%0b o=%0b",
                     cycle_count, want.tile_x, want.tile_y, want.tile_z,
                     want.last_of_run, want.span_overflow);
            $display("%0d:               got x=%0d y=%0d z=%0d l=%0b o=%0b",
                     cycle_count, out_data.tile_x, out_data.tile_y, out_data.tile_z,
                     out_data.last_of_run, out_data.span_overflow);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_point();
    test_line_octants();
    test_span_limits();
    test_random_strokes();
    wait_tiles_drained();
    if (fail_count == 0 && expected_tiles.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
